// ===== src/pidtc_pkg.sv =====
// ----------------------------------------------------------------------------
// PID temperature controller package
// Shared widths, register indexes, reset values and stage word types.
// ----------------------------------------------------------------------------
package pidtc_pkg;

    localparam int TEMP_W     = 16;
    localparam int ERR_W      = TEMP_W + 1;
    localparam int SUM_W      = 16;
    localparam int SUMRAW_W   = ERR_W + 1;
    localparam int DERIV_W    = ERR_W + 1;
    localparam int GAIN_W     = 12;
    localparam int LIMIT_W    = 15;
    localparam int DUTY_W     = 11;
    localparam int PROD_P_W   = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W   = GAIN_W + 1 + SUM_W;
    localparam int PROD_D_W   = GAIN_W + 1 + DERIV_W;
    localparam int TOTAL_W    = 32;
    localparam int FRAC_W     = 8;
    localparam int QUOT_W     = TOTAL_W - FRAC_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUM_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX  = 3'd4;

    localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 12'd512;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 12'd38;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 12'd13;
    localparam logic [LIMIT_W-1:0] SUM_LIMIT_RST = 15'd8000;
    localparam logic [DUTY_W-1:0]  DUTY_MAX_RST  = 11'd1600;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [GAIN_W-1:0]  gain_d;
        logic [LIMIT_W-1:0] sum_limit;
        logic [DUTY_W-1:0]  duty_max;
    } cfg_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] target;
        logic signed [TEMP_W-1:0] measured;
        logic                     restart;
    } sample_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [SUM_W-1:0]   sum;
        logic signed [DERIV_W-1:0] deriv;
        logic                      sum_clamped;
    } terms_t;

    typedef struct packed {
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
        logic                       sum_clamped;
    } prods_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              sum_clamped;
        logic              duty_clamped;
    } result_t;

endpackage

// ===== src/pidtc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// PID configuration registers
// Gain, sum limit and duty maximum registers behind a valid/ready write port.
// ----------------------------------------------------------------------------
module pidtc_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pidtc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pidtc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pidtc_pkg::cfg_t                    cfg
);

    pidtc_pkg::cfg_t cfg_reg;
    pidtc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                pidtc_pkg::REG_GAIN_P:    cfg_next.gain_p    = cfg_data[pidtc_pkg::GAIN_W-1:0];
                pidtc_pkg::REG_GAIN_I:    cfg_next.gain_i    = cfg_data[pidtc_pkg::GAIN_W-1:0];
                pidtc_pkg::REG_GAIN_D:    cfg_next.gain_d    = cfg_data[pidtc_pkg::GAIN_W-1:0];
                pidtc_pkg::REG_SUM_LIMIT: cfg_next.sum_limit = cfg_data[pidtc_pkg::LIMIT_W-1:0];
                pidtc_pkg::REG_DUTY_MAX:  cfg_next.duty_max  = cfg_data[pidtc_pkg::DUTY_W-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p    <= pidtc_pkg::GAIN_P_RST;
            cfg_reg.gain_i    <= pidtc_pkg::GAIN_I_RST;
            cfg_reg.gain_d    <= pidtc_pkg::GAIN_D_RST;
            cfg_reg.sum_limit <= pidtc_pkg::SUM_LIMIT_RST;
            cfg_reg.duty_max  <= pidtc_pkg::DUTY_MAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/pidtc_err_stage.sv =====
// ----------------------------------------------------------------------------
// PID error stage
// Input register, then error, clamped sum and derivative with loop state.
// ----------------------------------------------------------------------------
module pidtc_err_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pidtc_pkg::cfg_t      cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pidtc_pkg::sample_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pidtc_pkg::terms_t    out_data
);

    logic                                   sample_valid_reg;
    pidtc_pkg::sample_t                     sample_reg;
    logic                                   terms_valid_reg;
    pidtc_pkg::terms_t                      terms_reg;
    pidtc_pkg::terms_t                      terms_next;
    logic signed [pidtc_pkg::SUM_W-1:0]     error_sum_reg;
    logic signed [pidtc_pkg::ERR_W-1:0]     last_error_reg;
    logic                                   terms_ready;
    logic                                   advance;
    logic signed [pidtc_pkg::SUM_W-1:0]     base_sum;
    logic signed [pidtc_pkg::ERR_W-1:0]     base_last;
    logic signed [pidtc_pkg::SUMRAW_W-1:0]  sum_raw;
    logic signed [pidtc_pkg::SUMRAW_W-1:0]  lim_pos;
    logic signed [pidtc_pkg::SUMRAW_W-1:0]  lim_neg;

    assign terms_ready = !terms_valid_reg || out_ready;
    assign in_ready    = !sample_valid_reg || terms_ready;
    assign advance     = sample_valid_reg && terms_ready;
    assign out_valid   = terms_valid_reg;
    assign out_data    = terms_reg;

    always_comb begin
        base_sum  = sample_reg.restart ? '0 : error_sum_reg;
        base_last = sample_reg.restart ? '0 : last_error_reg;
        terms_next.err = pidtc_pkg::ERR_W'(sample_reg.target)
                       - pidtc_pkg::ERR_W'(sample_reg.measured);
        sum_raw = pidtc_pkg::SUMRAW_W'(base_sum) + pidtc_pkg::SUMRAW_W'(terms_next.err);
        lim_pos = signed'({3'b000, cfg.sum_limit});
        lim_neg = -lim_pos;
        terms_next.sum_clamped = 1'b1;
        priority if (sum_raw > lim_pos) begin
            terms_next.sum = lim_pos[pidtc_pkg::SUM_W-1:0];
        end else if (sum_raw < lim_neg) begin
            terms_next.sum = lim_neg[pidtc_pkg::SUM_W-1:0];
        end else begin
            terms_next.sum         = sum_raw[pidtc_pkg::SUM_W-1:0];
            terms_next.sum_clamped = 1'b0;
        end
        terms_next.deriv = pidtc_pkg::DERIV_W'(terms_next.err)
                         - pidtc_pkg::DERIV_W'(base_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_valid_reg <= 1'b0;
            terms_valid_reg  <= 1'b0;
            error_sum_reg    <= '0;
            last_error_reg   <= '0;
        end else begin
            if (in_ready) begin
                sample_valid_reg <= in_valid;
            end
            if (terms_ready) begin
                terms_valid_reg <= sample_valid_reg;
            end
            if (advance) begin
                error_sum_reg  <= terms_next.sum;
                last_error_reg <= terms_next.err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            sample_reg <= in_data;
        end
        if (advance) begin
            terms_reg <= terms_next;
        end
    end

endmodule

// ===== src/pidtc_mult_stage.sv =====
// ----------------------------------------------------------------------------
// PID product stage
// Three signed gain multiplies into one product register.
// ----------------------------------------------------------------------------
module pidtc_mult_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pidtc_pkg::cfg_t      cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pidtc_pkg::terms_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pidtc_pkg::prods_t    out_data
);

    logic                valid_reg;
    pidtc_pkg::prods_t   prods_reg;
    pidtc_pkg::prods_t   prods_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = prods_reg;

    always_comb begin
        prods_next.prod_p = pidtc_pkg::PROD_P_W'(signed'({1'b0, cfg.gain_p}))
                          * pidtc_pkg::PROD_P_W'(in_data.err);
        prods_next.prod_i = pidtc_pkg::PROD_I_W'(signed'({1'b0, cfg.gain_i}))
                          * pidtc_pkg::PROD_I_W'(in_data.sum);
        prods_next.prod_d = pidtc_pkg::PROD_D_W'(signed'({1'b0, cfg.gain_d}))
                          * pidtc_pkg::PROD_D_W'(in_data.deriv);
        prods_next.sum_clamped = in_data.sum_clamped;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            prods_reg <= prods_next;
        end
    end

endmodule

// ===== src/pidtc_out_stage.sv =====
// ----------------------------------------------------------------------------
// PID output stage
// Add the weighted terms, floor by the gain fraction and clamp the duty.
// ----------------------------------------------------------------------------
module pidtc_out_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pidtc_pkg::cfg_t      cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pidtc_pkg::prods_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pidtc_pkg::result_t   out_data
);

    logic                                 valid_reg;
    pidtc_pkg::result_t                   result_reg;
    pidtc_pkg::result_t                   result_next;
    logic signed [pidtc_pkg::TOTAL_W-1:0] total;
    logic [pidtc_pkg::QUOT_W-1:0]         quot;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = result_reg;

    always_comb begin
        total = pidtc_pkg::TOTAL_W'(in_data.prod_p)
              + pidtc_pkg::TOTAL_W'(in_data.prod_i)
              + pidtc_pkg::TOTAL_W'(in_data.prod_d);
        quot  = total[pidtc_pkg::TOTAL_W-1:pidtc_pkg::FRAC_W];
        result_next.sum_clamped = in_data.sum_clamped;
        priority if (total < 0) begin
            result_next.duty         = '0;
            result_next.duty_clamped = 1'b1;
        end else if (quot > pidtc_pkg::QUOT_W'(cfg.duty_max)) begin
            result_next.duty         = cfg.duty_max;
            result_next.duty_clamped = 1'b1;
        end else begin
            result_next.duty         = quot[pidtc_pkg::DUTY_W-1:0];
            result_next.duty_clamped = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            result_reg <= result_next;
        end
    end

endmodule

// ===== src/pid_temperature_controller.sv =====
// ----------------------------------------------------------------------------
// PID temperature controller
// Path: a word accepted into the sample register moves through the terms, product
//   and result registers to m_tvalid. Throughput: one word per cycle unless m_tready
//   stalls; the error sum and previous error update per word, which allows this rate.
// Reset: aresetn low clears all stage valids, the error sum and the previous
//   error, and loads the gains, sum limit and duty maximum with defaults.
// ----------------------------------------------------------------------------
module pid_temperature_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,   // [15:0] target_temp, [31:16] measured_temp
    input  logic                              s_tuser,   // [0] restart
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [10:0] drive_duty, [15:11] zero
    output logic [1:0]                        m_tuser,   // [0] sum_clamped, [1] duty_clamped
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pidtc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pidtc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pidtc_pkg::cfg_t     cfg;
    pidtc_pkg::sample_t  sample;
    pidtc_pkg::terms_t   terms;
    pidtc_pkg::prods_t   prods;
    pidtc_pkg::result_t  result;
    logic                terms_valid;
    logic                terms_ready;
    logic                prods_valid;
    logic                prods_ready;

    // Unpack the input word into its fields.
    assign sample.target   = s_tdata[15:0];
    assign sample.measured = s_tdata[31:16];
    assign sample.restart  = s_tuser;

    pidtc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Register the sample, then form error, clamped sum and derivative.
    // The loop state advances as each word leaves the input register.
    pidtc_err_stage u_err (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (sample),
        .out_valid (terms_valid),
        .out_ready (terms_ready),
        .out_data  (terms)
    );

    // Weight each term by its gain.
    pidtc_mult_stage u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (terms_valid),
        .in_ready  (terms_ready),
        .in_data   (terms),
        .out_valid (prods_valid),
        .out_ready (prods_ready),
        .out_data  (prods)
    );

    // Add, floor and clamp into the output register; each stage holds its
    // word only while the next one is full and stalled.
    pidtc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (prods_valid),
        .in_ready  (prods_ready),
        .in_data   (prods),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    assign m_tdata = {{(16 - pidtc_pkg::DUTY_W){1'b0}}, result.duty};
    assign m_tuser = {result.duty_clamped, result.sum_clamped};

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    logic signed [pidtc_pkg::SUM_W:0] lim_chk;
    assign lim_chk = signed'({2'b00, cfg.sum_limit});

    // The stored sum always sits inside the configured limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        terms_valid |-> (pidtc_pkg::SUM_W'(terms.sum) == terms.sum) &&
                        ((pidtc_pkg::SUM_W+1)'(terms.sum) <= lim_chk) &&
                        ((pidtc_pkg::SUM_W+1)'(terms.sum) >= -lim_chk))
        else $error("error sum outside limit");

    // Duty never exceeds the configured maximum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (result.duty <= cfg.duty_max))
        else $error("duty above maximum");

    // A clamped duty sits at one of the two rails.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result.duty_clamped) |->
            ((result.duty == '0) || (result.duty == cfg.duty_max)))
        else $error("clamped duty off rail");

    // Input backpressure only comes from a full, stalled output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output free");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// PID temperature controller testbench
// Streams target/measured temperature words into the controller and checks
// each duty word against a cycle-free model of the loop. The model holds its
// own error sum, previous error and register copies. Register settings change
// between phases while the block is idle. Both stream sides idle at random,
// and one phase holds the result side off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;

    // quiet cycles allowed before the run is declared hung
    localparam int QUIET_LIMIT = 2000;
    // receiver hold-off for the back-pressure phase
    localparam int LONG_HOLD   = 250;

    typedef struct packed {
        logic [pidtc_pkg::CFG_IDX_W-1:0]  index;
        logic [pidtc_pkg::CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [31:0]                      s_tdata   = '0;  // [15:0] target_temp, [31:16] measured_temp
    logic                             s_tuser   = 1'b0; // [0] restart
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [15:0]                      m_tdata;         // [10:0] drive_duty, [15:11] zero
    logic [1:0]                       m_tuser;         // [0] sum_clamped, [1] duty_clamped
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [pidtc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pidtc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // pending stimulus and expected duty words
    pidtc_pkg::sample_t sample_q[$];
    reg_write_t         reg_write_q[$];
    pidtc_pkg::result_t expected_duty_q[$];

    // model copy of the registers and the loop state
    int kp_gain   = int'(pidtc_pkg::GAIN_P_RST);
    int ki_gain   = int'(pidtc_pkg::GAIN_I_RST);
    int kd_gain   = int'(pidtc_pkg::GAIN_D_RST);
    int sum_clamp = int'(pidtc_pkg::SUM_LIMIT_RST);
    int duty_top  = int'(pidtc_pkg::DUTY_MAX_RST);
    int err_sum   = 0;
    int prev_err  = 0;

    // traffic shaping, set by the sequencer
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit hold_req  = 1'b0;

    int mismatch_cnt = 0;
    int quiet_cycles = 0;

    pid_temperature_controller i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 55) return 0;
        if (r < 88) return int'($urandom_range(1, 3));
        if (r < 97) return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    // Advance the loop by one sample and return the duty word it must produce.
    function automatic pidtc_pkg::result_t loop_predict(input pidtc_pkg::sample_t smp);
        int                 err;
        int                 sum;
        int                 deriv;
        longint             total;
        pidtc_pkg::result_t res;
        res = '0;
        // restart drops the history before this sample is folded in
        if (smp.restart) begin
            err_sum  = 0;
            prev_err = 0;
        end
        err = int'($signed(smp.target)) - int'($signed(smp.measured));
        sum = err_sum + err;
        if (sum > sum_clamp) begin
            sum = sum_clamp;
            res.sum_clamped = 1'b1;
        end else if (sum < -sum_clamp) begin
            sum = -sum_clamp;
            res.sum_clamped = 1'b1;
        end
        err_sum  = sum;
        deriv    = err - prev_err;
        prev_err = err;
        total = longint'(kp_gain) * longint'(err) + longint'(ki_gain) * longint'(sum)
              + longint'(kd_gain) * longint'(deriv);
        // a negative drive pins to zero; a small positive one just floors
        if (total < 0) begin
            res.duty_clamped = 1'b1;
        end else if ((total >>> pidtc_pkg::FRAC_W) > longint'(duty_top)) begin
            res.duty         = pidtc_pkg::DUTY_W'(duty_top);
            res.duty_clamped = 1'b1;
        end else begin
            res.duty = pidtc_pkg::DUTY_W'(total >>> pidtc_pkg::FRAC_W);
        end
        return res;
    endfunction

    // Mirror a register write; unknown indexes are dropped by the block.
    function automatic void reg_update(input reg_write_t w);
        case (w.index)
            pidtc_pkg::REG_GAIN_P:    kp_gain   = int'(w.data[pidtc_pkg::GAIN_W-1:0]);
            pidtc_pkg::REG_GAIN_I:    ki_gain   = int'(w.data[pidtc_pkg::GAIN_W-1:0]);
            pidtc_pkg::REG_GAIN_D:    kd_gain   = int'(w.data[pidtc_pkg::GAIN_W-1:0]);
            pidtc_pkg::REG_SUM_LIMIT: sum_clamp = int'(w.data[pidtc_pkg::LIMIT_W-1:0]);
            pidtc_pkg::REG_DUTY_MAX:  duty_top  = int'(w.data[pidtc_pkg::DUTY_W-1:0]);
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input driver: present queued samples, predict at acceptance.
    // ------------------------------------------------------------------
    pidtc_pkg::sample_t tx_word;
    int                 tx_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_duty_q.push_back(loop_predict(tx_word));
            end
            // hold the word until taken, then advance or idle
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0 && !tx_steady) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    tx_word = sample_q.pop_front();
                    s_tdata  <= {tx_word.measured, tx_word.target};
                    s_tuser  <= tx_word.restart;
                    s_tvalid <= 1'b1;
                    tx_gap = tx_steady ? 0 : gap_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Register write driver: one write in flight, model updated on accept.
    // ------------------------------------------------------------------
    reg_write_t cfg_word;

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                reg_update(cfg_word);
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_write_q.size() > 0) begin
                    cfg_word = reg_write_q.pop_front();
                    cfg_index <= cfg_word.index;
                    cfg_data  <= cfg_word.data;
                    cfg_valid <= 1'b1;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each duty word with the oldest prediction,
    // and throttle m_tready.
    // ------------------------------------------------------------------
    int                 rx_stall = 0;
    pidtc_pkg::result_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_duty_q.size() == 0) begin
                    $display("%0t: unexpected duty word %0d, tuser %b", $time, m_tdata, m_tuser);
                    mismatch_cnt++;
                end else begin
                    want = expected_duty_q.pop_front();
                    if (m_tdata !== {{(16 - pidtc_pkg::DUTY_W){1'b0}}, want.duty}) begin
                        $display("%0t: drive_duty expected %0d, got %0d",
                                 $time, want.duty, m_tdata);
                        mismatch_cnt++;
                    end
                    if (m_tuser[0] !== want.sum_clamped) begin
                        $display("%0t: sum_clamped expected %0d, got %0d",
                                 $time, want.sum_clamped, m_tuser[0]);
                        mismatch_cnt++;
                    end
                    if (m_tuser[1] !== want.duty_clamped) begin
                        $display("%0t: duty_clamped expected %0d, got %0d",
                                 $time, want.duty_clamped, m_tuser[1]);
                        mismatch_cnt++;
                    end
                end
            end
            // a long hold-off request overrides whatever gap is running
            if (hold_req) begin
                rx_stall = LONG_HOLD;
                hold_req = 1'b0;
            end else if (rx_stall == 0 && !rx_steady) begin
                rx_stall = gap_len();
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if no word moves on any channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[pid_temperature_controller] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    task automatic push_sample(input int tgt, input int mea, input bit rst);
        pidtc_pkg::sample_t smp;
        smp.target   = 16'(tgt);
        smp.measured = 16'(mea);
        smp.restart  = rst;
        sample_q.push_back(smp);
    endtask

    task automatic set_reg(input logic [pidtc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pidtc_pkg::CFG_DATA_W-1:0] val);
        reg_write_t w;
        w.index = idx;
        w.data  = val;
        reg_write_q.push_back(w);
    endtask

    // Wait until every queued word is taken and every duty word is back,
    // then let the pipeline drain.
    task automatic settle();
        while (sample_q.size() != 0 || s_tvalid || reg_write_q.size() != 0 || cfg_valid
               || expected_duty_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register value: zero, the top, the default, or raw bits (upper ones masked).
    function automatic logic [pidtc_pkg::CFG_DATA_W-1:0] pick_value(input int top,
                                                                    input int dflt);
        int r;
        r = int'($urandom_range(0, 3));
        if (r == 0) return '0;
        if (r == 1) return pidtc_pkg::CFG_DATA_W'(top);
        if (r == 2) return pidtc_pkg::CFG_DATA_W'(dflt);
        return pidtc_pkg::CFG_DATA_W'($urandom());
    endfunction

    task automatic random_regs();
        if ($urandom_range(0, 2) == 0)
            set_reg(pidtc_pkg::CFG_IDX_W'($urandom_range(5, 7)),
                    pidtc_pkg::CFG_DATA_W'($urandom()));
        set_reg(pidtc_pkg::REG_GAIN_P, pick_value(4095, int'(pidtc_pkg::GAIN_P_RST)));
        set_reg(pidtc_pkg::REG_GAIN_I, pick_value(4095, int'(pidtc_pkg::GAIN_I_RST)));
        set_reg(pidtc_pkg::REG_GAIN_D, pick_value(4095, int'(pidtc_pkg::GAIN_D_RST)));
        set_reg(pidtc_pkg::REG_SUM_LIMIT, pick_value(32767, int'(pidtc_pkg::SUM_LIMIT_RST)));
        set_reg(pidtc_pkg::REG_DUTY_MAX, pick_value(2047, int'(pidtc_pkg::DUTY_MAX_RST)));
    endtask

    // Mostly heating runs that open with a restart and drift toward the
    // set point; the rest is raw noise with random restarts.
    task automatic add_random(input int n);
        int left;
        int run;
        int setp;
        int meas;
        int k;
        left = n;
        while (left > 0) begin
            if ($urandom_range(0, 4) == 0) begin
                push_sample(int'($urandom()), int'($urandom()), 1'($urandom_range(0, 1)));
                left--;
            end else begin
                run  = int'($urandom_range(5, 30));
                setp = int'($urandom_range(0, 6000)) - 1000;
                meas = setp - int'($urandom_range(0, 1600)) + 200;
                for (k = 0; k < run && left > 0; k++) begin
                    push_sample(setp, meas, k == 0);
                    meas = meas + int'($urandom_range(0, 60)) - 20;
                    left--;
                end
            end
        end
    endtask

    initial begin
        int p;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default gains: zero start, both error extremes, sum clamp both ways
        push_sample(0, 0, 1'b1);
        push_sample(160, 100, 1'b0);
        push_sample(32767, -32768, 1'b0);
        push_sample(-32768, 32767, 1'b0);
        push_sample(-32768, 32767, 1'b0);
        push_sample(0, 0, 1'b1);
        push_sample(100, 110, 1'b0);
        push_sample(1000, 0, 1'b0);
        settle();

        // P gain of 1/256, zero sum limit, duty top above nominal; junk in the
        // upper data bits and writes to unknown indexes must be dropped
        set_reg(3'd5, 15'h7FFF);
        set_reg(pidtc_pkg::REG_GAIN_P, 15'h7001);
        set_reg(pidtc_pkg::REG_GAIN_I, 15'd0);
        set_reg(pidtc_pkg::REG_GAIN_D, 15'd0);
        set_reg(pidtc_pkg::REG_SUM_LIMIT, 15'd0);
        set_reg(pidtc_pkg::REG_DUTY_MAX, 15'h7FFF);
        set_reg(3'd7, 15'h1234);
        settle();
        push_sample(100, 0, 1'b1);
        push_sample(0, 0, 1'b0);
        push_sample(32767, -32768, 1'b0);
        push_sample(-1, 0, 1'b0);
        settle();

        // full-scale gains and sum limit
        set_reg(pidtc_pkg::REG_GAIN_P, 15'd4095);
        set_reg(pidtc_pkg::REG_GAIN_I, 15'd4095);
        set_reg(pidtc_pkg::REG_GAIN_D, 15'd4095);
        set_reg(pidtc_pkg::REG_SUM_LIMIT, 15'd32767);
        settle();
        push_sample(32767, -32768, 1'b1);
        push_sample(32767, -32768, 1'b0);
        push_sample(10, 9, 1'b1);
        push_sample(-32768, 32767, 1'b0);
        settle();

        // everything at zero: drive floors to zero with no duty clamp
        set_reg(pidtc_pkg::REG_GAIN_P, 15'd0);
        set_reg(pidtc_pkg::REG_GAIN_I, 15'd0);
        set_reg(pidtc_pkg::REG_GAIN_D, 15'd0);
        set_reg(pidtc_pkg::REG_SUM_LIMIT, 15'd0);
        set_reg(pidtc_pkg::REG_DUTY_MAX, 15'd0);
        settle();
        push_sample(5, 0, 1'b0);
        push_sample(0, 5, 1'b0);
        push_sample(0, 0, 1'b1);
        settle();

        for (p = 0; p < 8; p++) begin
            random_regs();
            settle();
            // phase 2 runs flat out on both sides; phase 5 backs up the input
            tx_steady = (p == 2 || p == 5);
            rx_steady = (p == 2);
            if (p == 5) hold_req = 1'b1;
            if (p == 6) begin
                // pause the sender mid-phase until every duty word is back
                add_random(52);
                settle();
                add_random(52);
            end else begin
                add_random(104);
            end
            settle();
            tx_steady = 1'b0;
            rx_steady = 1'b0;
        end

        repeat (8) @(posedge aclk);
        if (mismatch_cnt == 0 && expected_duty_q.size() == 0)
            $display("[pid_temperature_controller] OK");
        else
            $display("[pid_temperature_controller] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/pidtc_pkg.sv
src/pidtc_cfg_regs.sv
src/pidtc_err_stage.sv
src/pidtc_mult_stage.sv
src/pidtc_out_stage.sv
src/pid_temperature_controller.sv
bench/tb.sv
